FILE: hw/rtl/tccw_pkg.sv
// Package with shared constants and types for the console cell writer.
`timescale 1ns / 1ps
package tccw_pkg;
  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW = $clog2(CELLS);

  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_BLANK = 8'h20;

  localparam logic [2:0] OP_PRINT = 3'd0;
  localparam logic [2:0] OP_SETCUR = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_SCROLL = 3'd3;
  localparam logic [2:0] OP_READ = 3'd4;
  localparam logic [2:0] OP_HIDE = 3'd5;
  localparam logic [2:0] OP_SHOW = 3'd6;

  localparam logic CFG_ATTR = 1'b0;
  localparam logic CFG_TAB = 1'b1;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] character;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] scroll_lines;
    logic [10:0] cell_address;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DECIDE, ST_MOD, ST_TAB, ST_MOVE_RD, ST_MOVE_WR, ST_FILL, ST_READ,
    ST_READ2, ST_DONE
  } state_t;
endpackage

FILE: hw/rtl/text_console_cell_writer_top.sv
// Top level of the text console cell writer.
// Tabs first find the column phase with a bitwise modulo and then write one blank per cycle.
// Clears write one screen cell per cycle; scrolls copy each kept cell with a read and then
// a write and blank the freed rows. The back end runs one command at a time.
// A two-entry command queue accepts new commands while the back end works, until it is full.
// Synchronous active-low reset: cursor at (0,0) shown, attribute 7, tab 8, and a pass over
// all 2000 cells that zeroes the screen before the first command runs.
`timescale 1ns / 1ps
module text_console_cell_writer_top (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [2:0] in_op,
  input  logic [7:0] in_character,
  input  logic [7:0] in_column,
  input  logic [7:0] in_row,
  input  logic [7:0] in_scroll_lines,
  input  logic [10:0] in_cell_address,
  output logic out_valid,
  output logic [15:0] out_cursor_position,
  output logic [7:0] out_cursor_column,
  output logic [7:0] out_cursor_row,
  output logic out_cursor_visible,
  output logic [7:0] out_cell_character,
  output logic [7:0] out_cell_attribute,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  tccw_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;

  assign in_cmd = '{op: in_op, character: in_character, column: in_column, row: in_row,
                    scroll_lines: in_scroll_lines, cell_address: in_cell_address};
  assign cfg_ready = 1'b1;

  tccw_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_cmd(in_cmd),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  tccw_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .cfg_valid(cfg_valid && cfg_index[1] == 1'b0), .cfg_index(cfg_index[0]),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_cursor_position(out_cursor_position),
    .out_cursor_column(out_cursor_column), .out_cursor_row(out_cursor_row),
    .out_cursor_visible(out_cursor_visible), .out_cell_character(out_cell_character),
    .out_cell_attribute(out_cell_attribute)
  );
endmodule

FILE: hw/rtl/tccw_front.sv
// Front end: accepts commands and holds them in a two-entry queue.
`timescale 1ns / 1ps
module tccw_front (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  tccw_pkg::cmd_t in_cmd,
  output logic q_valid,
  output tccw_pkg::cmd_t q_cmd,
  input  logic q_pop
);
  tccw_pkg::cmd_t mem_r [2];
  logic rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push;

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = mem_r[rd_r];

  always_comb begin
    rd_nxt = q_pop ? ~rd_r : rd_r;
    wr_nxt = push ? ~wr_r : wr_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wr_r] <= in_cmd;
  end
endmodule

FILE: hw/rtl/tccw_back.sv
// Back end: executes console commands against the screen memory.
`timescale 1ns / 1ps
module tccw_back (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  tccw_pkg::cmd_t q_cmd,
  output logic q_pop,
  input  logic cfg_valid,
  input  logic cfg_index,
  input  logic [7:0] cfg_data,
  output logic out_valid,
  output logic [15:0] out_cursor_position,
  output logic [7:0] out_cursor_column,
  output logic [7:0] out_cursor_row,
  output logic out_cursor_visible,
  output logic [7:0] out_cell_character,
  output logic [7:0] out_cell_attribute
);
  localparam int AW = tccw_pkg::AW;
  localparam logic [AW-1:0] CELLS_A = AW'(tccw_pkg::CELLS);
  localparam logic [AW-1:0] COLS_A = AW'(tccw_pkg::COLUMNS);
  localparam logic [7:0] COLS8 = 8'(tccw_pkg::COLUMNS);
  localparam logic [7:0] ROWS8 = 8'(tccw_pkg::ROWS);

  logic [15:0] mem [tccw_pkg::CELLS];
  logic [15:0] rdata_r;
  logic mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [15:0] mem_wd;

  tccw_pkg::state_t st_r, st_nxt;
  tccw_pkg::cmd_t cmd_r, cmd_nxt;
  logic [7:0] col_r, col_nxt, line_r, line_nxt;
  logic shown_r, shown_nxt;
  logic [7:0] attr_r;
  logic [4:0] tab_r;
  logic [AW-1:0] ptr_r, ptr_nxt, end_r, end_nxt, src_off_r, src_off_nxt;
  logic [4:0] tcnt_r, tcnt_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [AW-1:0] cur_idx;
  logic [15:0] blank;
  logic [7:0] rc_r, rc_nxt, ra_r, ra_nxt;
  logic ov_r, ov_nxt;
  logic [7:0] nlines;
  logic [7:0] mod_r, mod_nxt, mod_rem;
  logic [2:0] mbit_r, mbit_nxt;
  logic [4:0] ts_eff;
  logic [12:0] mod_sub;

  assign blank = {attr_r, tccw_pkg::CH_BLANK};
  assign cur_idx = AW'(pos_r);
  assign nlines = cmd_r.scroll_lines;
  assign ts_eff = (tab_r == 5'd0) ? 5'd1 : tab_r;
  assign mod_sub = 13'(ts_eff) << mbit_r;
  assign mod_rem = ({5'd0, mod_r} >= mod_sub) ? mod_r - mod_sub[7:0] : mod_r;

  always_comb begin
    st_nxt = st_r;
    cmd_nxt = cmd_r;
    col_nxt = col_r;
    line_nxt = line_r;
    shown_nxt = shown_r;
    ptr_nxt = ptr_r;
    end_nxt = end_r;
    src_off_nxt = src_off_r;
    tcnt_nxt = tcnt_r;
    mod_nxt = mod_r;
    mbit_nxt = mbit_r;
    q_pop = 1'b0;
    mem_we = 1'b0;
    mem_wa = ptr_r;
    mem_wd = blank;
    mem_ra = ptr_r + src_off_r;
    rc_nxt = 8'd0;
    ra_nxt = 8'd0;
    ov_nxt = 1'b0;
    case (st_r)
      tccw_pkg::ST_INIT: begin
        if (ptr_r == CELLS_A) begin
          st_nxt = tccw_pkg::ST_IDLE;
        end else begin
          mem_we = 1'b1;
          mem_wd = '0;
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      tccw_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          cmd_nxt = q_cmd;
          st_nxt = tccw_pkg::ST_DECIDE;
        end
      end
      tccw_pkg::ST_DECIDE: begin
        st_nxt = tccw_pkg::ST_DONE;
        case (cmd_r.op)
          tccw_pkg::OP_PRINT: begin
            if (col_r < COLS8 && line_r < ROWS8) begin
              if (cmd_r.character == tccw_pkg::CH_NEWLINE) begin
                col_nxt = 8'd0;
                line_nxt = line_r + 8'd1;
                st_nxt = tccw_pkg::ST_TAB;
                tcnt_nxt = 5'd0;
              end else if (cmd_r.character == tccw_pkg::CH_TAB) begin
                ptr_nxt = cur_idx;
                mod_nxt = col_r;
                mbit_nxt = 3'd7;
                st_nxt = tccw_pkg::ST_MOD;
              end else begin
                mem_we = 1'b1;
                mem_wa = cur_idx;
                mem_wd = {attr_r, cmd_r.character};
                col_nxt = col_r + 8'd1;
                tcnt_nxt = 5'd0;
                st_nxt = tccw_pkg::ST_TAB;
              end
            end
          end
          tccw_pkg::OP_SETCUR: begin
            col_nxt = cmd_r.column;
            line_nxt = cmd_r.row;
          end
          tccw_pkg::OP_CLEAR: begin
            ptr_nxt = '0;
            end_nxt = CELLS_A;
            col_nxt = 8'd0;
            line_nxt = 8'd0;
            st_nxt = tccw_pkg::ST_FILL;
          end
          tccw_pkg::OP_SCROLL: begin
            if (nlines >= ROWS8) begin
              ptr_nxt = '0;
              end_nxt = CELLS_A;
              col_nxt = 8'd0;
              line_nxt = 8'd0;
              st_nxt = tccw_pkg::ST_FILL;
            end else if (nlines != 8'd0) begin
              src_off_nxt = AW'(16'(nlines) * 16'(tccw_pkg::COLUMNS));
              ptr_nxt = '0;
              end_nxt = CELLS_A - AW'(16'(nlines) * 16'(tccw_pkg::COLUMNS));
              line_nxt = (line_r >= nlines) ? line_r - nlines : 8'd0;
              st_nxt = tccw_pkg::ST_MOVE_RD;
            end
          end
          tccw_pkg::OP_READ: st_nxt = tccw_pkg::ST_READ;
          tccw_pkg::OP_HIDE: shown_nxt = 1'b0;
          tccw_pkg::OP_SHOW: shown_nxt = 1'b1;
          default: ;
        endcase
      end
      tccw_pkg::ST_MOD: begin
        mod_nxt = mod_rem;
        if (mbit_r == 3'd0) begin
          tcnt_nxt = ts_eff - mod_rem[4:0];
          st_nxt = tccw_pkg::ST_TAB;
        end else begin
          mbit_nxt = mbit_r - 3'd1;
        end
      end
      tccw_pkg::ST_TAB: begin
        if (tcnt_r != 5'd0 && col_r < COLS8) begin
          mem_we = 1'b1;
          mem_wa = cur_idx;
          col_nxt = col_r + 8'd1;
          tcnt_nxt = tcnt_r - 5'd1;
        end else begin
          st_nxt = tccw_pkg::ST_DONE;
          if (col_r >= COLS8) begin
            col_nxt = 8'd0;
            line_nxt = line_r + 8'd1;
          end
          if (line_nxt >= ROWS8) begin
            line_nxt = line_nxt - 8'd1;
            src_off_nxt = COLS_A;
            ptr_nxt = '0;
            end_nxt = CELLS_A - COLS_A;
            st_nxt = tccw_pkg::ST_MOVE_RD;
          end
        end
      end
      tccw_pkg::ST_MOVE_RD: begin
        if (ptr_r == end_r) begin
          end_nxt = CELLS_A;
          st_nxt = tccw_pkg::ST_FILL;
        end else begin
          st_nxt = tccw_pkg::ST_MOVE_WR;
        end
      end
      tccw_pkg::ST_MOVE_WR: begin
        mem_we = 1'b1;
        mem_wd = rdata_r;
        ptr_nxt = ptr_r + AW'(1);
        st_nxt = tccw_pkg::ST_MOVE_RD;
      end
      tccw_pkg::ST_FILL: begin
        if (ptr_r == end_r) begin
          st_nxt = tccw_pkg::ST_DONE;
        end else begin
          mem_we = 1'b1;
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      tccw_pkg::ST_READ: begin
        mem_ra = AW'(cmd_r.cell_address);
        st_nxt = tccw_pkg::ST_READ2;
      end
      tccw_pkg::ST_READ2: begin
        mem_ra = AW'(cmd_r.cell_address);
        st_nxt = tccw_pkg::ST_DONE;
      end
      tccw_pkg::ST_DONE: begin
        ov_nxt = 1'b1;
        if (cmd_r.op == tccw_pkg::OP_READ && {5'd0, cmd_r.cell_address} < 16'(tccw_pkg::CELLS)) begin
          rc_nxt = rdata_r[7:0];
          ra_nxt = rdata_r[15:8];
        end
        st_nxt = tccw_pkg::ST_IDLE;
      end
      default: st_nxt = tccw_pkg::ST_IDLE;
    endcase
    pos_nxt = 16'(line_nxt) * 16'(tccw_pkg::COLUMNS) + 16'(col_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tccw_pkg::ST_INIT;
      col_r <= 8'd0;
      line_r <= 8'd0;
      shown_r <= 1'b1;
      attr_r <= 8'd7;
      tab_r <= 5'd8;
      pos_r <= 16'd0;
      ov_r <= 1'b0;
      ptr_r <= '0;
    end else begin
      st_r <= st_nxt;
      col_r <= col_nxt;
      line_r <= line_nxt;
      shown_r <= shown_nxt;
      pos_r <= pos_nxt;
      ov_r <= ov_nxt;
      ptr_r <= ptr_nxt;
      if (cfg_valid) begin
        if (cfg_index == tccw_pkg::CFG_ATTR) attr_r <= cfg_data;
        else if (cfg_index == tccw_pkg::CFG_TAB) tab_r <= cfg_data[4:0];
      end
    end
    cmd_r <= cmd_nxt;
    end_r <= end_nxt;
    src_off_r <= src_off_nxt;
    tcnt_r <= tcnt_nxt;
    mod_r <= mod_nxt;
    mbit_r <= mbit_nxt;
    rc_r <= rc_nxt;
    ra_r <= ra_nxt;
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[mem_ra];
  end

  assign out_valid = ov_r;
  assign out_cursor_position = pos_r;
  assign out_cursor_column = col_r;
  assign out_cursor_row = line_r;
  assign out_cursor_visible = shown_r;
  assign out_cell_character = rc_r;
  assign out_cell_attribute = ra_r;
endmodule
